[hw/rtl/wsc_pkg.sv]
// Shared constants, codes and the front-to-back token type of the section checker.
`timescale 1ns / 1ps
`default_nettype none

package wsc_pkg;

    localparam int unsigned LENGTH_WIDTH_DEF   = 32;
    localparam int unsigned MAX_SIZE_BYTES_DEF = 5;

    // Header is magic (4 bytes) plus version (4 bytes)
    localparam int unsigned HDR_BYTES = 8;

    localparam logic [7:0] MAGIC_B0      = 8'h00;
    localparam logic [7:0] MAGIC_B1      = 8'h61;
    localparam logic [7:0] MAGIC_WASM_B2 = 8'h73;
    localparam logic [7:0] MAGIC_WASM_B3 = 8'h6D;
    localparam logic [7:0] MAGIC_AOT_B2  = 8'h6F;
    localparam logic [7:0] MAGIC_AOT_B3  = 8'h74;
    localparam logic [31:0] WASM_VERSION = 32'd1;

    localparam logic [7:0] CUSTOM_SECTION_ID = 8'h00;

    // Byte offsets within the header
    localparam logic [2:0] HDR_MAGIC0 = 3'd0;
    localparam logic [2:0] HDR_MAGIC1 = 3'd1;
    localparam logic [2:0] HDR_MAGIC2 = 3'd2;
    localparam logic [2:0] HDR_MAGIC3 = 3'd3;
    localparam logic [2:0] HDR_VER0   = 3'd4;
    localparam logic [2:0] HDR_VER1   = 3'd5;
    localparam logic [2:0] HDR_VER2   = 3'd6;
    localparam logic [2:0] HDR_VER3   = 3'd7;

    // Configuration register index (word address bit)
    localparam logic CFG_IMAGE_LENGTH = 1'b0;
    localparam logic [31:0] IMAGE_LENGTH_RESET = 32'd8;

    typedef enum logic [2:0] {
        ST_PASS    = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_TRUNC   = 3'd4
    } status_t;

    // Bytes left after the current one, capped at 2^32 (sizes never exceed 2^32-1)
    localparam int unsigned REM_WIDTH = 33;
    localparam logic [REM_WIDTH-1:0] REM_CAP = 33'h1_0000_0000;

    typedef struct packed {
        logic [7:0]           data;
        logic [2:0]           hdr_pos;
        logic                 last;
        logic                 short_len;
        logic [REM_WIDTH-1:0] rem;
    } wsc_token_t;

endpackage

`default_nettype wire

[hw/rtl/wsc_if.sv]
// Valid/ready channel interfaces for image bytes and verdicts.
`timescale 1ns / 1ps
`default_nettype none

interface wsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;

    modport source (output valid, output image_byte, input ready);
    modport sink   (input valid, input image_byte, output ready);
endinterface

interface wsc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        image_kind;
    logic [31:0] complete_sections;
    logic        order_warning;
    logic [31:0] detail;

    modport source (output valid, output status, output image_kind, output complete_sections,
                    output order_warning, output detail, input ready);
    modport sink   (input valid, input status, input image_kind, input complete_sections,
                    input order_warning, input detail, output ready);
endinterface

`default_nettype wire

[hw/rtl/wasm_section_structure_checker.sv]
// Top level: configuration register, front end, token queue and parser of the image checker.
//
//   Channel   Direction  Handshake         Payload
//   image     in         valid/ready       image_byte[7:0]
//   verdict   out        valid/ready       status, image_kind, complete_sections,
//                                          order_warning, detail
//   config    in         APB, pready = 1   image_length (word 0)
//
// One byte per cycle while the queue has room; the queue and the output register decouple the sides.
// A verdict is registered: the byte that decides it passes the queue, then the output register.
// The front end's length compare and the parser's size-versus-remaining compare set the pace.
// Reset: image_length is 8 and the parser waits for the header of a new image.
// Input stalls only when the two-entry queue is full; the queue fills while the verdict
// output is held by its sink.
`timescale 1ns / 1ps
`default_nettype none

module wasm_section_structure_checker
    import wsc_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH   = LENGTH_WIDTH_DEF,
    parameter int unsigned MAX_SIZE_BYTES = MAX_SIZE_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    wsc_byte_if.sink         image,
    wsc_result_if.source     verdict,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] image_length_reg;
    logic [31:0] image_length_next;
    logic        cfg_write;

    wsc_token_t  f_tok;
    logic        f_valid;
    logic        f_ready;
    wsc_token_t  q_tok;
    logic        q_valid;
    logic        q_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == CFG_IMAGE_LENGTH);
    assign prdata    = (paddr[2] == CFG_IMAGE_LENGTH) ? image_length_reg : '0;

    always_comb
    begin
        image_length_next = cfg_write ? pwdata : image_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg <= IMAGE_LENGTH_RESET;
        end
        else
        begin
            image_length_reg <= image_length_next;
        end
    end

    wsc_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_length (image_length_reg),
        .image        (image),
        .tok          (f_tok),
        .tok_valid    (f_valid),
        .tok_ready    (f_ready)
    );

    wsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_tok   (f_tok),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_tok    (q_tok),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    wsc_back #(
        .MAX_SIZE_BYTES (MAX_SIZE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (q_tok),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .verdict   (verdict)
    );

    // a queued token waiting on the parser must not change
    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_tok))
        else $error("queued token changed while stalled");

    // a new verdict needs a token consumed in the cycle before
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict.valid) |-> $past(q_valid && q_ready))
        else $error("verdict raised without a consumed byte");

    // AOT verdicts are passes without section data
    a_aot_pass: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid && verdict.image_kind |->
            verdict.status == ST_PASS && verdict.complete_sections == '0
            && !verdict.order_warning && verdict.detail == '0)
        else $error("AOT verdict carries section data or an error");

    // detail is only used for version and truncation errors
    a_detail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid && (verdict.status == ST_PASS || verdict.status == ST_SHORT
            || verdict.status == ST_MAGIC) |-> verdict.detail == '0)
        else $error("detail set on a verdict that has none");

endmodule

`default_nettype wire

[hw/rtl/wsc_front.sv]
// Front end: accepts bytes, tracks the byte position and tags each byte for the parser.
`timescale 1ns / 1ps
`default_nettype none

module wsc_front
    import wsc_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] image_length,
    wsc_byte_if.sink         image,
    output wsc_token_t       tok,
    output logic             tok_valid,
    input  wire logic        tok_ready
);

    localparam int unsigned CW = (LENGTH_WIDTH > REM_WIDTH) ? LENGTH_WIDTH : REM_WIDTH;

    logic [LENGTH_WIDTH-1:0] pos_reg;
    logic [LENGTH_WIDTH-1:0] pos_next;
    logic [LENGTH_WIDTH-1:0] len;
    logic [LENGTH_WIDTH-1:0] rem;
    logic [CW-1:0]           rem_ext;
    logic                    last;
    logic                    accept;

    assign len     = LENGTH_WIDTH'(image_length);
    // zero length behaves as a one-byte image
    assign last    = (len == '0) || (pos_reg >= (len - LENGTH_WIDTH'(1)));
    assign rem     = last ? '0 : (len - LENGTH_WIDTH'(1) - pos_reg);
    assign rem_ext = CW'(rem);

    always_comb
    begin
        tok.data      = image.image_byte;
        tok.hdr_pos   = pos_reg[2:0];
        tok.last      = last;
        tok.short_len = (len < LENGTH_WIDTH'(HDR_BYTES));
        tok.rem       = (rem_ext > CW'(REM_CAP)) ? REM_CAP : rem_ext[REM_WIDTH-1:0];
    end

    assign tok_valid   = image.valid;
    assign image.ready = tok_ready;
    assign accept      = image.valid && tok_ready;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = last ? '0 : (pos_reg + LENGTH_WIDTH'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wsc_queue.sv]
// Two-entry token queue between the front end and the parser.
`timescale 1ns / 1ps
`default_nettype none

module wsc_queue
    import wsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire wsc_token_t  push_tok,
    input  wire logic        push_valid,
    output logic             push_ready,
    output wsc_token_t       pop_tok,
    output logic             pop_valid,
    input  wire logic        pop_ready
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    wsc_token_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wsc_back.sv]
// Parser: checks the header, walks sections and holds the verdict in an output register.
`timescale 1ns / 1ps
`default_nettype none

module wsc_back
    import wsc_pkg::*;
#(
    parameter int unsigned MAX_SIZE_BYTES = MAX_SIZE_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire wsc_token_t tok,
    input  wire logic       tok_valid,
    output logic            tok_ready,
    wsc_result_if.source    verdict
);

    localparam int unsigned CNT_W = $clog2(MAX_SIZE_BYTES + 1);

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_ID      = 6'b000010,
        PH_SIZE    = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_BODY    = 6'b010000,
        PH_SKIP    = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] hword_reg, hword_next;
    logic [31:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] left_reg, left_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [7:0]  prev_id_reg, prev_id_next;
    logic [31:0] sections_reg, sections_next;
    logic        warn_reg, warn_next;
    logic        aot_reg, aot_next;

    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg;
    logic        out_kind_reg;
    logic [31:0] out_count_reg;
    logic        out_warn_reg;
    logic [31:0] out_detail_reg;

    logic        tok_pop;
    logic        emit;
    status_t     res_status;
    logic        res_kind;
    logic [31:0] res_count;
    logic        res_warn;
    logic [31:0] res_detail;

    logic [5:0]       shamt;
    logic [63:0]      piece;
    logic [31:0]      acc_new;
    logic [CNT_W-1:0] cnt_new;
    logic [31:0]      version;
    logic [31:0]      left_dec;

    assign tok_ready = !out_valid_reg || verdict.ready;
    assign tok_pop   = tok_valid && tok_ready;

    // LEB128 group placement; groups above bit 31 drop out
    assign shamt    = 6'(cnt_reg) * 6'd7;
    assign piece    = 64'(tok.data[6:0]) << shamt;
    assign acc_new  = acc_reg | piece[31:0];
    assign cnt_new  = cnt_reg + CNT_W'(1);
    assign version  = {tok.data, hword_reg};
    assign left_dec = left_reg - 32'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        hword_next    = hword_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        left_next     = left_reg;
        cur_id_next   = cur_id_reg;
        prev_id_next  = prev_id_reg;
        sections_next = sections_reg;
        warn_next     = warn_reg;
        aot_next      = aot_reg;
        emit          = 1'b0;
        res_status    = ST_PASS;
        res_kind      = 1'b0;
        res_count     = '0;
        res_warn      = 1'b0;
        res_detail    = '0;

        if (tok_pop)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (tok.short_len)
                    begin
                        emit       = 1'b1;
                        res_status = ST_SHORT;
                    end
                    else
                    begin
                        unique case (tok.hdr_pos)
                            HDR_MAGIC0:
                            begin
                                if (tok.data != MAGIC_B0)
                                begin
                                    emit       = 1'b1;
                                    res_status = ST_MAGIC;
                                end
                            end
                            HDR_MAGIC1:
                            begin
                                if (tok.data != MAGIC_B1)
                                begin
                                    emit       = 1'b1;
                                    res_status = ST_MAGIC;
                                end
                            end
                            HDR_MAGIC2:
                            begin
                                if (tok.data == MAGIC_WASM_B2)
                                begin
                                    aot_next = 1'b0;
                                end
                                else if (tok.data == MAGIC_AOT_B2)
                                begin
                                    aot_next = 1'b1;
                                end
                                else
                                begin
                                    emit       = 1'b1;
                                    res_status = ST_MAGIC;
                                end
                            end
                            HDR_MAGIC3:
                            begin
                                if (tok.data != (aot_reg ? MAGIC_AOT_B3 : MAGIC_WASM_B3))
                                begin
                                    emit       = 1'b1;
                                    res_status = ST_MAGIC;
                                end
                            end
                            HDR_VER0: hword_next[7:0]   = tok.data;
                            HDR_VER1: hword_next[15:8]  = tok.data;
                            HDR_VER2: hword_next[23:16] = tok.data;
                            HDR_VER3:
                            begin
                                if (aot_reg)
                                begin
                                    phase_next = PH_BODY;
                                end
                                else if (version != WASM_VERSION)
                                begin
                                    emit       = 1'b1;
                                    res_status = ST_VERSION;
                                    res_detail = version;
                                end
                                else
                                begin
                                    phase_next = PH_ID;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                PH_ID:
                begin
                    cur_id_next = tok.data;
                    if (tok.data != CUSTOM_SECTION_ID && tok.data <= prev_id_reg
                        && sections_reg != '0)
                    begin
                        warn_next = 1'b1;
                    end
                    if (tok.data != CUSTOM_SECTION_ID)
                    begin
                        prev_id_next = tok.data;
                    end
                    acc_next = '0;
                    cnt_next = '0;
                    // image ending right after an id closes a zero-size section
                    if (tok.last)
                    begin
                        sections_next = sections_reg + 32'd1;
                    end
                    else
                    begin
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_new;
                    if (!tok.data[7] || cnt_new >= CNT_W'(MAX_SIZE_BYTES) || tok.last)
                    begin
                        if ({1'b0, acc_new} > tok.rem)
                        begin
                            emit       = 1'b1;
                            res_status = ST_TRUNC;
                            res_count  = sections_reg;
                            res_warn   = warn_reg;
                            res_detail = 32'(cur_id_reg);
                        end
                        else if (acc_new == '0)
                        begin
                            sections_next = sections_reg + 32'd1;
                            phase_next    = PH_ID;
                        end
                        else
                        begin
                            left_next  = acc_new;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (left_reg != '0)
                    begin
                        left_next = left_dec;
                    end
                    if (left_reg == '0 || left_dec == '0)
                    begin
                        sections_next = sections_reg + 32'd1;
                        phase_next    = PH_ID;
                    end
                end
                PH_BODY, PH_SKIP: ;
                default: ;
            endcase

            // drop the rest of the image after an error
            if (emit)
            begin
                phase_next = PH_SKIP;
            end

            if (tok.last)
            begin
                if (!emit && phase_next != PH_SKIP)
                begin
                    emit       = 1'b1;
                    res_status = ST_PASS;
                    res_kind   = aot_next;
                    res_count  = aot_next ? '0 : sections_next;
                    res_warn   = aot_next ? 1'b0 : warn_next;
                end
                phase_next    = PH_HEADER;
                hword_next    = '0;
                acc_next      = '0;
                cnt_next      = '0;
                left_next     = '0;
                cur_id_next   = '0;
                prev_id_next  = '0;
                sections_next = '0;
                warn_next     = 1'b0;
                aot_next      = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tok_pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hword_reg     <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            cur_id_reg    <= '0;
            prev_id_reg   <= '0;
            sections_reg  <= '0;
            warn_reg      <= 1'b0;
            aot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hword_reg     <= hword_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            cur_id_reg    <= cur_id_next;
            prev_id_reg   <= prev_id_next;
            sections_reg  <= sections_next;
            warn_reg      <= warn_next;
            aot_reg       <= aot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && emit)
        begin
            out_status_reg <= res_status;
            out_kind_reg   <= res_kind;
            out_count_reg  <= res_count;
            out_warn_reg   <= res_warn;
            out_detail_reg <= res_detail;
        end
    end

    assign verdict.valid             = out_valid_reg;
    assign verdict.status            = out_status_reg;
    assign verdict.image_kind        = out_kind_reg;
    assign verdict.complete_sections = out_count_reg;
    assign verdict.order_warning     = out_warn_reg;
    assign verdict.detail            = out_detail_reg;

endmodule

`default_nettype wire
